FILE: hdl/tvr_pkg.sv
package tvr_pkg;

	// field widths
	localparam int SpeedW = 24;
	localparam int DistW  = 32;
	localparam int ScaleW = 32;
	localparam int SqW    = 2 * SpeedW;
	localparam int ProdW  = SpeedW + ScaleW;
	localparam int StopW  = 33;
	localparam int WideW  = 41;

	// register reset values
	localparam logic [SpeedW-1:0] StepReset  = 24'd256;
	localparam logic [ScaleW-1:0] ScaleReset = 32'd0;

	// saturation bounds for a 32-bit signed result
	localparam logic signed [WideW-1:0] SatMax = 41'sd2147483647;
	localparam logic signed [WideW-1:0] SatMin = -41'sd2147483648;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_PLO,
		ST_PHI,
		ST_CMP,
		ST_UPD,
		ST_MAG,
		ST_DRV,
		ST_ERR,
		ST_FB
	} state_t;

	typedef enum logic [1:0] {
		MUL_SQ,
		MUL_LO,
		MUL_HI,
		MUL_OUT
	} mul_sel_t;

	typedef enum logic [1:0] {
		REG_STEP_ACCEL   = 2'd0,
		REG_STEP_DECEL   = 2'd1,
		REG_DECEL_SCALE  = 2'd2,
		REG_OUTPUT_SCALE = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [SpeedW-1:0] step_accel;
		logic [SpeedW-1:0] step_decel;
		logic [ScaleW-1:0] decel_scale;
		logic [ScaleW-1:0] output_scale;
	} cfg_t;

	typedef struct packed {
		logic     ld_in;
		mul_sel_t mul_sel;
		logic     ld_sq;
		logic     ld_plo;
		logic     ld_prod;
		logic     cmp;
		logic     upd;
		logic     drv;
		logic     err_add;
		logic     fire;
	} dp_cmd_t;

	// clamp a wide signed value to the 32-bit signed range
	function automatic logic signed [DistW-1:0] sat32(input logic signed [WideW-1:0] v);
		logic signed [DistW-1:0] r;
		if (v > SatMax) begin
			r = SatMax[DistW-1:0];
		end else if (v < SatMin) begin
			r = SatMin[DistW-1:0];
		end else begin
			r = v[DistW-1:0];
		end
		return r;
	endfunction

endpackage

FILE: hdl/tvr_regs.sv
module tvr_regs
	import tvr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	// writes are always taken
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// register file decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_accel   <= StepReset;
			cfg_q.step_decel   <= StepReset;
			cfg_q.decel_scale  <= ScaleReset;
			cfg_q.output_scale <= ScaleReset;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_STEP_ACCEL:   cfg_q.step_accel   <= cfg_data[SpeedW-1:0];
				REG_STEP_DECEL:   cfg_q.step_decel   <= cfg_data[SpeedW-1:0];
				REG_DECEL_SCALE:  cfg_q.decel_scale  <= cfg_data;
				REG_OUTPUT_SCALE: cfg_q.output_scale <= cfg_data;
			endcase
		end
	end

endmodule

FILE: hdl/tvr_ctrl.sv
module tvr_ctrl
	import tvr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   slot_free;

	// result slot can take a new result when empty or being drained
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_nxt = ST_SQ;
			ST_SQ:   state_nxt = ST_PLO;
			ST_PLO:  state_nxt = ST_PHI;
			ST_PHI:  state_nxt = ST_CMP;
			ST_CMP:  state_nxt = ST_UPD;
			ST_UPD:  state_nxt = ST_MAG;
			ST_MAG:  state_nxt = ST_DRV;
			ST_DRV:  state_nxt = ST_ERR;
			ST_ERR:  state_nxt = ST_FB;
			ST_FB:   if (slot_free) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd         = '0;
		cmd.mul_sel = MUL_SQ;
		in_ready    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.ld_in  = in_valid;
			end
			ST_SQ: begin
				cmd.mul_sel = MUL_SQ;
				cmd.ld_sq   = 1'b1;
			end
			ST_PLO: begin
				cmd.mul_sel = MUL_LO;
				cmd.ld_plo  = 1'b1;
			end
			ST_PHI: begin
				cmd.mul_sel = MUL_HI;
				cmd.ld_prod = 1'b1;
			end
			ST_CMP:  cmd.cmp = 1'b1;
			ST_UPD:  cmd.upd = 1'b1;
			ST_MAG: begin
				cmd.mul_sel = MUL_OUT;
				cmd.ld_prod = 1'b1;
			end
			ST_DRV:  cmd.drv = 1'b1;
			ST_ERR:  cmd.err_add = 1'b1;
			ST_FB:   cmd.fire = slot_free;
			default: cmd = '0;
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hdl/tvr_dp.sv
module tvr_dp
	import tvr_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  dp_cmd_t                  cmd,
	input  cfg_t                     cfg,
	input  logic                     mode,
	input  logic [SpeedW-1:0]        target_speed,
	input  logic signed [DistW-1:0]  remaining_distance,
	input  logic                     brake_enable,
	input  logic signed [DistW-1:0]  measured_step,
	output logic signed [DistW-1:0]  drive_step,
	output logic [SpeedW-1:0]        speed_now
);

	// captured request
	logic                    mode_q;
	logic [SpeedW-1:0]       target_q;
	logic signed [DistW-1:0] dist_q;
	logic                    brake_en_q;
	logic signed [DistW-1:0] meas_q;

	// ramp state
	logic [SpeedW-1:0]       speed_q;
	logic signed [DistW-1:0] err_q;

	// intermediates
	logic [SqW-1:0]          sq_q;
	logic [DistW-1:0]        plo_q;
	logic [ProdW-1:0]        prod_q;
	logic                    hit_q;
	logic signed [DistW-1:0] drive_q;
	logic signed [DistW-1:0] out_drive_q;
	logic [SpeedW-1:0]       out_speed_q;

	logic [SpeedW-1:0]       mul_a;
	logic [ScaleW-1:0]       mul_b;
	logic [ProdW-1:0]        mul_p;
	logic [ProdW:0]          stop_sum;
	logic [StopW-1:0]        stop;
	logic [DistW-1:0]        adist;
	logic                    hit;
	logic                    dec;
	logic signed [SpeedW+1:0] spd_w;
	logic signed [SpeedW+1:0] tgt_w;
	logic signed [SpeedW+1:0] spd_nxt;
	logic [SpeedW-1:0]       spd_clamp;
	logic signed [WideW-1:0] mag_w;
	logic signed [WideW-1:0] drive_w;
	logic signed [WideW-1:0] sum_w;
	logic signed [WideW-1:0] diff_w;

	// shared 24x32 multiplier operand select
	always_comb begin
		case (cmd.mul_sel)
			MUL_SQ: begin
				mul_a = speed_q;
				mul_b = {{(ScaleW-SpeedW){1'b0}}, speed_q};
			end
			MUL_LO: begin
				mul_a = sq_q[SpeedW-1:0];
				mul_b = cfg.decel_scale;
			end
			MUL_HI: begin
				mul_a = sq_q[SqW-1:SpeedW];
				mul_b = cfg.decel_scale;
			end
			default: begin
				mul_a = speed_q;
				mul_b = cfg.output_scale;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// stopping distance: (hi + lo>>24) >> 24
	assign stop_sum = {1'b0, prod_q} + {{(ProdW+1-DistW){1'b0}}, plo_q};
	assign stop     = stop_sum[ProdW:ProdW-StopW+1];
	assign adist    = dist_q[DistW-1] ? DistW'(-dist_q) : DistW'(dist_q);
	assign hit      = brake_en_q && ({1'b0, adist} <= stop);

	// speed update and clamp to [0, target]
	always_comb begin
		spd_w = {2'b00, speed_q};
		tgt_w = {2'b00, target_q};
		dec   = (speed_q > target_q) || hit_q;
		if (dec) begin
			spd_nxt = spd_w - {2'b00, cfg.step_decel};
		end else if (speed_q < target_q) begin
			spd_nxt = spd_w + {2'b00, cfg.step_accel};
		end else begin
			spd_nxt = spd_w;
		end
		if (spd_nxt > tgt_w) begin
			spd_clamp = target_q;
		end else if (spd_nxt < 0) begin
			spd_clamp = '0;
		end else begin
			spd_clamp = spd_nxt[SpeedW-1:0];
		end
	end

	// signed setpoint and error feedback sums
	assign mag_w   = {1'b0, prod_q[ProdW-1:16]};
	assign drive_w = dist_q[DistW-1] ? -mag_w : mag_w;
	assign sum_w   = {{(WideW-DistW){drive_q[DistW-1]}}, drive_q}
			+ {{(WideW-DistW){err_q[DistW-1]}}, err_q};
	assign diff_w  = {{(WideW-DistW){drive_q[DistW-1]}}, drive_q}
			- {{(WideW-DistW){meas_q[DistW-1]}}, meas_q};

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			mode_q     <= mode;
			target_q   <= target_speed;
			dist_q     <= remaining_distance;
			brake_en_q <= brake_enable;
			meas_q     <= measured_step;
		end
		if (cmd.ld_sq) begin
			sq_q <= mul_p[SqW-1:0];
		end
		if (cmd.ld_plo) begin
			plo_q <= mul_p[ProdW-1:SpeedW];
		end
		if (cmd.ld_prod) begin
			prod_q <= mul_p;
		end
		if (cmd.cmp) begin
			hit_q <= hit;
		end
		if (cmd.drv) begin
			drive_q <= sat32(drive_w);
		end else if (cmd.err_add && mode_q) begin
			drive_q <= sat32(sum_w);
		end
		if (cmd.fire) begin
			out_drive_q <= drive_q;
			out_speed_q <= speed_q;
		end
	end

	// ramp state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= '0;
			err_q   <= '0;
		end else begin
			if (cmd.upd) begin
				speed_q <= spd_clamp;
			end
			if (cmd.fire && mode_q) begin
				err_q <= sat32(diff_w);
			end
		end
	end

	assign drive_step = out_drive_q;
	assign speed_now  = out_speed_q;

endmodule

FILE: hdl/trapezoidal_velocity_ramp_core.sv
// request accept to result valid is paced by the sequencer
// walking one shared 24x32 multiplier through square, two scale partials, output scale
// one request at a time; next request taken while a result waits, but FB holds until the slot frees
// reset: asynchronous active low; clears speed, carried error, sequencer and result valid
// reset: step_accel and step_decel return to 256, decel_scale and output_scale to 0
module trapezoidal_velocity_ramp_core
	import tvr_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     mode,
	input  logic [SpeedW-1:0]        target_speed,
	input  logic signed [DistW-1:0]  remaining_distance,
	input  logic                     brake_enable,
	input  logic signed [DistW-1:0]  measured_step,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DistW-1:0]  drive_step,
	output logic [SpeedW-1:0]        speed_now,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [1:0]               cfg_index,
	input  logic [31:0]              cfg_data
);

	cfg_t    cfg;
	dp_cmd_t cmd;

	// configuration registers
	tvr_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencer
	tvr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// arithmetic
	tvr_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.cfg                (cfg),
		.mode               (mode),
		.target_speed       (target_speed),
		.remaining_distance (remaining_distance),
		.brake_enable       (brake_enable),
		.measured_step      (measured_step),
		.drive_step         (drive_step),
		.speed_now          (speed_now)
	);

endmodule

FILE: bench/tb_ramp_pkg.sv
package tb_ramp_pkg;
	import tvr_pkg::*;

	// one predicted tick result
	typedef struct {
		logic signed [DistW-1:0] drive;
		logic [SpeedW-1:0]       speed;
	} tick_out_t;

	class ramp_tracker;
		// register copies
		logic [SpeedW-1:0] accel_step = StepReset;
		logic [SpeedW-1:0] decel_step = StepReset;
		logic [ScaleW-1:0] brake_gain = ScaleReset;
		logic [ScaleW-1:0] out_gain   = ScaleReset;

		// ramp state
		logic [SpeedW-1:0] ramp_speed = '0;
		longint            err_carry  = 0;

		tick_out_t due_ticks[$];
		int        errors = 0;

		// one line per mismatch, quiet after a while
		function void report(string msg);
			if (errors < 40) begin
				$display("mismatch: %s", msg);
			end
			errors++;
		endfunction

		function longint clip32(longint v);
			if (v > 64'sd2147483647) begin
				return 64'sd2147483647;
			end
			if (v < -64'sd2147483648) begin
				return -64'sd2147483648;
			end
			return v;
		endfunction

		function void write_reg(reg_idx_t idx, logic [31:0] data);
			case (idx)
				REG_STEP_ACCEL:   accel_step = data[SpeedW-1:0];
				REG_STEP_DECEL:   decel_step = data[SpeedW-1:0];
				REG_DECEL_SCALE:  brake_gain = data;
				REG_OUTPUT_SCALE: out_gain   = data;
				default: ;
			endcase
		endfunction

		function int pending();
			return due_ticks.size();
		endfunction

		// advance the ramp by one tick and queue the expected result
		function void log_tick(logic mode, logic [SpeedW-1:0] target,
			logic signed [DistW-1:0] remain, logic brake, logic signed [DistW-1:0] meas);
			logic [79:0] sq;
			logic [79:0] stop_len;
			longint      spd;
			longint      tgt;
			longint      dst;
			longint      adst;
			longint      mag;
			longint      drv;
			tick_out_t   r;
			// stopping distance from the speed before the update
			sq       = 80'(ramp_speed) * 80'(ramp_speed);
			stop_len = (sq * 80'(brake_gain)) >> 48;
			spd  = longint'({40'd0, ramp_speed});
			tgt  = longint'({40'd0, target});
			dst  = longint'(remain);
			adst = (dst < 0) ? -dst : dst;
			// slow down, speed up, then clamp into [0, target]
			if (spd > tgt || (brake && (80'(adst) <= stop_len))) begin
				spd -= longint'({40'd0, decel_step});
			end else if (spd < tgt) begin
				spd += longint'({40'd0, accel_step});
			end
			if (spd > tgt) begin
				spd = tgt;
			end
			if (spd < 0) begin
				spd = 0;
			end
			ramp_speed = spd[SpeedW-1:0];
			// travel setpoint with the sign of the distance
			mag = (longint'({40'd0, ramp_speed}) * longint'({32'd0, out_gain})) >>> 16;
			drv = clip32((dst < 0) ? -mag : mag);
			if (mode) begin
				drv       = clip32(drv + err_carry);
				err_carry = clip32(drv - longint'(meas));
			end
			r.drive = drv[DistW-1:0];
			r.speed = ramp_speed;
			due_ticks.push_back(r);
		endfunction

		// compare a result with the oldest expectation
		function void check_tick(logic signed [DistW-1:0] drive, logic [SpeedW-1:0] speed);
			tick_out_t e;
			if (due_ticks.size() == 0) begin
				report($sformatf("result with nothing due: drive %0d speed %0d", drive, speed));
				return;
			end
			e = due_ticks.pop_front();
			if (drive !== e.drive) begin
				report($sformatf("drive_step %0d, predicted %0d", drive, e.drive));
			end
			if (speed !== e.speed) begin
				report($sformatf("speed_now %0d, predicted %0d", speed, e.speed));
			end
		endfunction
	endclass

endpackage

FILE: bench/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tvr_pkg::*;
	import tb_ramp_pkg::*;

	localparam int IdleLimit = 5000;
	localparam int PhaseTicks = 200;
	localparam int PhaseCount = 8;

	typedef enum int {
		CFG_TUNED,
		CFG_WIDE,
		CFG_EDGES
	} cfg_style_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic                    mode = 1'b0;
	logic [SpeedW-1:0]       target_speed = '0;
	logic signed [DistW-1:0] remaining_distance = '0;
	logic                    brake_enable = 1'b0;
	logic signed [DistW-1:0] measured_step = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [DistW-1:0] drive_step;
	logic [SpeedW-1:0]       speed_now;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [1:0]              cfg_index = '0;
	logic [31:0]             cfg_data = '0;

	bit          calm = 1'b0;
	int          quiet_cycles = 0;
	ramp_tracker ramp = new();

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	trapezoidal_velocity_ramp_core uut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.mode               (mode),
		.target_speed       (target_speed),
		.remaining_distance (remaining_distance),
		.brake_enable       (brake_enable),
		.measured_step      (measured_step),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.drive_step         (drive_step),
		.speed_now          (speed_now),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data)
	);

	// follow register writes, requests and results
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				ramp.write_reg(reg_idx_t'(cfg_index), cfg_data);
			end
			if (in_valid && in_ready) begin
				ramp.log_tick(mode, target_speed, remaining_distance, brake_enable,
					measured_step);
			end
			if (out_valid && out_ready) begin
				ramp.check_tick(drive_step, speed_now);
			end
		end
	end

	// stall the result side
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 24);
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= IdleLimit) begin
			$display("trapezoidal_velocity_ramp_core regression: fail");
			$finish;
		end
	end

	function automatic logic signed [31:0] rand_signed();
		logic [31:0] v;
		v = $urandom >> $urandom_range(0, 31);
		return $urandom_range(1) ? -v : v;
	endfunction

	function automatic logic [SpeedW-1:0] pick_speed();
		return SpeedW'($urandom_range(24'hFFFFFF) >> $urandom_range(0, 12));
	endfunction

	// present one tick request after an optional gap
	task automatic send_tick(input logic m, input logic [SpeedW-1:0] tgt,
		input logic signed [DistW-1:0] remain, input logic brk,
		input logic signed [DistW-1:0] meas);
		if (!calm) begin
			while ($urandom_range(99) < 24) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid           <= 1'b1;
		mode               <= m;
		target_speed       <= tgt;
		remaining_distance <= remain;
		brake_enable       <= brk;
		measured_step      <= meas;
		do @(posedge clk); while (!in_ready);
	endtask

	// write all four registers in index order
	task automatic load_regs(input logic [31:0] accel, input logic [31:0] decel,
		input logic [31:0] brake_k, input logic [31:0] out_k);
		logic [31:0] vals[4];
		vals = '{accel, decel, brake_k, out_k};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= reg_idx_t'(i);
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	// hold requests until every result is back
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (ramp.pending() != 0);
	endtask

	task automatic pick_setup(input cfg_style_t style);
		case (style)
			CFG_TUNED: load_regs($urandom >> $urandom_range(8, 31), $urandom >> $urandom_range(8, 31),
				$urandom >> $urandom_range(0, 31), $urandom >> $urandom_range(8, 24));
			CFG_WIDE: load_regs($urandom, $urandom, $urandom, $urandom);
			default: load_regs($urandom_range(1) ? 32'hFFFFFF : 32'h0,
				$urandom_range(1) ? 32'hFFFFFF : 32'h0,
				$urandom_range(1) ? 32'hFFFFFFFF : 32'h0,
				$urandom_range(1) ? 32'hFFFFFFFF : 32'h0);
		endcase
	endtask

	initial begin
		int                      sent;
		int                      ticks;
		cfg_style_t              style;
		logic                    m;
		logic                    b;
		logic [SpeedW-1:0]       tgt;
		longint                  dl;
		longint                  stepsz;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values, zero distance always brakes
		send_tick(1'b0, 24'd1000, 32'sd500, 1'b0, 32'sd0);
		send_tick(1'b1, 24'hFFFFFF, -32'sd1, 1'b1, 32'sh7FFFFFFF);
		send_tick(1'b1, 24'hFFFFFF, 32'sd0, 1'b1, 32'sh80000000);
		send_tick(1'b0, 24'd0, 32'sd0, 1'b1, 32'shFFFFFFFF);
		settle();

		// largest settings: setpoint and carried error saturate both ways
		load_regs(32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_tick(1'b0, 24'hFFFFFF, 32'sh7FFFFFFF, 1'b1, 32'sd0);
		send_tick(1'b0, 24'hFFFFFF, 32'sh80000000, 1'b0, 32'sd0);
		send_tick(1'b1, 24'hFFFFFF, 32'sh80000000, 1'b0, 32'sh7FFFFFFF);
		send_tick(1'b1, 24'hFFFFFF, 32'sh7FFFFFFF, 1'b1, 32'sh80000000);
		send_tick(1'b1, 24'hFFFFFF, 32'sh80000000, 1'b1, 32'sd0);
		send_tick(1'b0, 24'd0, 32'sd1, 1'b0, 32'sd0);
		settle();

		// small steps, no deceleration, clamp to target
		load_regs(32'd64, 32'd0, 32'd0, 32'd0);
		send_tick(1'b0, 24'd100, 32'sd10, 1'b0, 32'sd0);
		send_tick(1'b0, 24'd100, 32'sd10, 1'b0, 32'sd0);
		send_tick(1'b0, 24'd50, 32'sd10, 1'b0, 32'sd0);
		send_tick(1'b1, 24'd50, -32'sd1, 1'b1, 32'sd5);
		settle();

		// unit output scale, braking near the goal
		load_regs(32'h000100, 32'h000080, 32'h00010000, 32'h00010000);
		send_tick(1'b0, 24'h000400, 32'sd40, 1'b1, 32'sd0);
		send_tick(1'b0, 24'h000400, 32'sd20, 1'b1, 32'sd0);
		send_tick(1'b1, 24'h000400, -32'sd2, 1'b1, -32'sd100);
		send_tick(1'b1, 24'h000400, 32'sd0, 1'b1, 32'sd100);
		settle();

		// random moves toward a goal, with some noise between them
		sent = 0;
		for (int phase = 0; phase < PhaseCount; phase++) begin
			settle();
			style = (phase % 4 == 3) ? CFG_EDGES : ((phase % 4 == 1) ? CFG_WIDE : CFG_TUNED);
			pick_setup(style);
			calm = (phase == 2);
			while (sent < (phase + 1) * PhaseTicks) begin
				if ($urandom_range(99) < 15) begin
					send_tick(1'($urandom_range(1)), SpeedW'($urandom_range(24'hFFFFFF)), $urandom,
						1'($urandom_range(1)), $urandom);
					sent++;
				end else begin
					tgt   = pick_speed();
					ticks = $urandom_range(4, 60);
					m     = ($urandom_range(99) < 25);
					b     = ($urandom_range(99) < 85);
					dl    = longint'($urandom >> $urandom_range(1, 31));
					if ($urandom_range(1)) begin
						dl = -dl;
					end
					for (int k = 0; k < ticks; k++) begin
						send_tick(m, tgt, 32'(dl), b, rand_signed());
						sent++;
						// close in on the goal, sometimes overshooting it
						stepsz = ((dl < 0) ? -dl : dl) / (ticks - k) + $urandom_range(3);
						if (dl > 0) begin
							dl -= stepsz;
						end else begin
							dl += stepsz;
						end
						if ($urandom_range(99) < 4) begin
							tgt = tgt >> 1;
						end
					end
				end
			end
		end
		calm = 1'b0;

		settle();
		repeat (20) @(posedge clk);
		if (ramp.errors == 0) begin
			$display("trapezoidal_velocity_ramp_core regression: pass");
		end else begin
			$display("trapezoidal_velocity_ramp_core regression: fail");
		end
		$finish;
	end

endmodule
